@@ sv/mfp_pkg.sv @@
// Shared types and constants for the monochrome framebuffer pixel plotter.
// No dependencies; every other file but mfp_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package mfp_pkg;

  // input item kinds as they arrive on kind_i
  typedef enum logic [1:0] {
    KIND_PLOT  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // operations carried from the front end to the back end
  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_INIT  = 2'd0,
    ST_RUN   = 2'd1,
    ST_SWEEP = 2'd2
  } back_state_e;

  // pen codes, anything above set toggles
  localparam logic [1:0] PEN_CLEAR = 2'd0;
  localparam logic [1:0] PEN_SET   = 2'd1;

  // store address field wide enough for the largest screen
  localparam int unsigned ADDR_W = 16;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_idx;
    logic [1:0]        pen;
    logic              zero;    // read beyond the store returns zero
  } cmd_t;

endpackage

@@ sv/mono_framebuffer_pixel_plotter_top.sv @@
// Top level of the monochrome framebuffer pixel plotter.
// Depends on mfp_pkg; instantiates mfp_front, mfp_queue and mfp_back.
`timescale 1ns / 1ps

// One-bit SCREEN_WIDTH x SCREEN_HEIGHT frame store, kept as pages of column
// bytes and flipped vertically. Plot items set, clear or toggle one pixel;
// off-screen points and unused kinds are dropped at the input. Read items
// return one byte, addressed as page * SCREEN_WIDTH + column, bit 0 being
// the top row of the page. Plot and read items run at one per cycle while
// nothing holds the back end, which writes the store in the cycle after it
// reads it, with the byte just written forwarded to a following access of
// the same address. A read waits in the back end while an earlier result is
// still unpopped. A clear item leaves the queue once the previous access has
// written, and then holds the back end while the sweep zeroes every store
// byte, one store byte per cycle, while a four-entry queue keeps taking
// input. After reset the same sweep runs once and full stays high while it
// runs. A result stays on read_byte_o until popped.
module mono_framebuffer_pixel_plotter_top #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic [1:0]         pen_i,
  input  logic [9:0]         read_address_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         read_byte_o
);

  logic          accept;
  logic          q_push;
  logic          q_full;
  logic          q_vld;
  logic          q_pop;
  logic          init_busy;
  mfp_pkg::cmd_t front_cmd;
  mfp_pkg::cmd_t head_cmd;

  // input request handshake
  assign full   = q_full || init_busy;
  assign accept = push && !full;

  mfp_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .accept_i       (accept),
    .kind_i         (kind_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .pen_i          (pen_i),
    .read_address_i (read_address_i),
    .q_push_o       (q_push),
    .cmd_o          (front_cmd)
  );

  mfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .head_o (head_cmd)
  );

  mfp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (q_vld),
    .head_i      (head_cmd),
    .head_pop_o  (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .read_byte_o (read_byte_o),
    .init_busy_o (init_busy)
  );

endmodule

@@ sv/mfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/mfp_front.sv @@
// Front end: classifies each accepted item and turns it into a store command.
// Depends on mfp_pkg for the kind and operation codes and the command type.
`timescale 1ns / 1ps

module mfp_front #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic               accept_i,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic [1:0]         pen_i,
  input  logic [9:0]         read_address_i,
  output logic               q_push_o,
  output mfp_pkg::cmd_t      cmd_o
);

  localparam int unsigned STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned FW = $clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8) + 1);

  logic [15:0]   xu;
  logic [15:0]   yu;
  logic          on_screen;
  logic [YW-1:0] inv_y;
  logic [FW-1:0] plot_addr;
  logic          plot_ok;
  logic          read_ok;

  assign xu = x_coord_i;
  assign yu = y_coord_i;

  // screen bounds check on the signed coordinates
  assign on_screen = !xu[15] && (xu < 16'(SCREEN_WIDTH)) &&
                     !yu[15] && (yu < 16'(SCREEN_HEIGHT));

  // vertical flip, then page and column to a byte address
  assign inv_y     = YW'(SCREEN_HEIGHT - 1) - yu[YW-1:0];
  assign plot_addr = FW'((inv_y >> 3) * SCREEN_WIDTH) + FW'(xu[XW-1:0]);
  assign plot_ok   = on_screen && (plot_addr < FW'(STORE_BYTES));

  // reads beyond the store still give a result, forced to zero
  assign read_ok = 17'(read_address_i) < 17'(STORE_BYTES);

  // build the command and decide whether it goes to the back end
  always_comb begin
    q_push_o      = 1'b0;
    cmd_o.op      = mfp_pkg::OP_PLOT;
    cmd_o.addr    = mfp_pkg::ADDR_W'(plot_addr);
    cmd_o.bit_idx = inv_y[2:0];
    cmd_o.pen     = pen_i;
    cmd_o.zero    = 1'b0;
    case (mfp_pkg::kind_e'(kind_i))
      mfp_pkg::KIND_PLOT: begin
        q_push_o = accept_i && plot_ok;
      end
      mfp_pkg::KIND_READ: begin
        q_push_o   = accept_i;
        cmd_o.op   = mfp_pkg::OP_READ;
        cmd_o.addr = mfp_pkg::ADDR_W'(read_address_i);
        cmd_o.zero = !read_ok;
      end
      mfp_pkg::KIND_CLEAR: begin
        q_push_o = accept_i;
        cmd_o.op = mfp_pkg::OP_CLEAR;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/mfp_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on mfp_pkg for the command type and queue sizing.
`timescale 1ns / 1ps

module mfp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfp_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output mfp_pkg::cmd_t head_o
);

  localparam int unsigned PW = mfp_pkg::QUEUE_PTR_W;

  mfp_pkg::cmd_t entry_q [mfp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = cnt_q == (PW + 1)'(mfp_pkg::QUEUE_DEPTH);
  assign vld_o   = cnt_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(do_push);
    rd_ptr_d = rd_ptr_q + PW'(do_pop);
    cnt_d    = cnt_q + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ sv/mfp_back.sv @@
// Back end: runs store commands against the frame RAM and holds the result.
// Depends on mfp_pkg and instantiates mfp_ram.
`timescale 1ns / 1ps

module mfp_back #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_vld_i,
  input  mfp_pkg::cmd_t head_i,
  output logic          head_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    read_byte_o,
  output logic          init_busy_o
);

  localparam int unsigned STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int unsigned AW = $clog2(STORE_BYTES);

  mfp_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;

  logic          s2_vld_q, s2_vld_d;
  mfp_pkg::cmd_t s2_cmd_q, s2_cmd_d;

  logic          wr_vld_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wr_data_q;

  logic          out_vld_q, out_vld_d;
  logic [7:0]    out_byte_q, out_byte_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          rd_en;
  logic [7:0]    rd_data;

  logic [AW-1:0] s2_addr;
  logic          s2_plot;
  logic          s2_read;
  logic          advance;
  logic [7:0]    cur_byte;
  logic [7:0]    bit_mask;
  logic [7:0]    new_byte;

  mfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (head_i.addr[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign s2_addr = s2_cmd_q.addr[AW-1:0];
  assign s2_plot = s2_vld_q && (s2_cmd_q.op == mfp_pkg::OP_PLOT);
  assign s2_read = s2_vld_q && (s2_cmd_q.op == mfp_pkg::OP_READ);

  // a read result waits only when the output register cannot take it
  assign advance = !(s2_read && out_vld_q && !pop_i);

  // forward the byte written while this one was being read
  assign cur_byte = (wr_vld_q && (wr_addr_q == s2_addr)) ? wr_data_q : rd_data;
  assign bit_mask = 8'd1 << s2_cmd_q.bit_idx;

  // pixel update
  always_comb begin
    case (s2_cmd_q.pen)
      mfp_pkg::PEN_CLEAR: new_byte = cur_byte & ~bit_mask;
      mfp_pkg::PEN_SET:   new_byte = cur_byte | bit_mask;
      default:            new_byte = cur_byte ^ bit_mask;
    endcase
  end

  // sequencer: issue, read-modify-write and clearing sweeps
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    head_pop_o = 1'b0;
    rd_en      = 1'b0;
    s2_vld_d   = s2_vld_q;
    s2_cmd_d   = s2_cmd_q;
    ram_we     = s2_plot;
    ram_waddr  = s2_addr;
    ram_wdata  = new_byte;
    if (advance) begin
      s2_vld_d = 1'b0;
    end
    case (state_q)
      mfp_pkg::ST_INIT, mfp_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(STORE_BYTES - 1)) begin
          state_d = mfp_pkg::ST_RUN;
          cnt_d   = '0;
        end
      end
      mfp_pkg::ST_RUN: begin
        if (head_vld_i && advance) begin
          if (head_i.op == mfp_pkg::OP_CLEAR) begin
            // let the last pixel write finish before the sweep
            if (!s2_vld_q) begin
              head_pop_o = 1'b1;
              state_d    = mfp_pkg::ST_SWEEP;
              cnt_d      = '0;
            end
          end else begin
            head_pop_o = 1'b1;
            rd_en      = 1'b1;
            s2_vld_d   = 1'b1;
            s2_cmd_d   = head_i;
          end
        end
      end
      default: begin
        state_d = mfp_pkg::ST_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_d  = out_vld_q && !pop_i;
    out_byte_d = out_byte_q;
    if (s2_read && advance) begin
      out_vld_d  = 1'b1;
      out_byte_d = s2_cmd_q.zero ? 8'd0 : cur_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfp_pkg::ST_INIT;
      cnt_q     <= '0;
      s2_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        wr_vld_q <= s2_plot;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s2_cmd_q   <= s2_cmd_d;
    out_byte_q <= out_byte_d;
    if (advance) begin
      wr_addr_q <= s2_addr;
      wr_data_q <= new_byte;
    end
  end

  assign empty_o     = !out_vld_q;
  assign read_byte_o = out_byte_q;
  assign init_busy_o = state_q == mfp_pkg::ST_INIT;

endmodule
